>>> hw/rtl/chc_pkg.sv
// chc_pkg: shared types, constants and the arctangent table for the
// calibrated compass heading block. No dependencies.
package chc_pkg;

	localparam int CAL_SAMPLES_DEF  = 70;
	localparam int AVG_SAMPLES_DEF  = 10;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int XW = 21;  // CORDIC x/y width
	localparam int ZW = 27;  // CORDIC angle width, degrees Q16

	localparam logic signed [ZW-1:0] ANG_180 = ZW'(180 * 65536);
	localparam logic signed [ZW-1:0] ANG_360 = ZW'(360 * 65536);
	localparam logic [16:0] Q_ONE = 17'h10000;
	localparam logic [16:0] H_WRAP = 17'd23040;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVGX,
		ST_AVGY,
		ST_NORMX,
		ST_NORMY,
		ST_CORD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic        neg;
		logic        sat;
		logic [17:0] absn;
		logic [15:0] span;
	} norm_ld_t;

	// atan(2^-i) in degrees Q16
	function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		unique case (i)
			5'd0:  r = ZW'(2949120);
			5'd1:  r = ZW'(1740967);
			5'd2:  r = ZW'(919879);
			5'd3:  r = ZW'(466945);
			5'd4:  r = ZW'(234379);
			5'd5:  r = ZW'(117304);
			5'd6:  r = ZW'(58666);
			5'd7:  r = ZW'(29335);
			5'd8:  r = ZW'(14668);
			5'd9:  r = ZW'(7334);
			5'd10: r = ZW'(3667);
			5'd11: r = ZW'(1833);
			5'd12: r = ZW'(917);
			5'd13: r = ZW'(458);
			5'd14: r = ZW'(229);
			5'd15: r = ZW'(115);
			5'd16: r = ZW'(57);
			5'd17: r = ZW'(29);
			5'd18: r = ZW'(14);
			5'd19: r = ZW'(7);
			5'd20: r = ZW'(4);
			5'd21: r = ZW'(2);
			5'd22: r = ZW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	// numerator 2*(a-lo)-span, its magnitude and the saturation check
	function automatic norm_ld_t norm_load(input logic signed [15:0] a,
			input logic signed [15:0] lo, input logic signed [15:0] hi);
		norm_ld_t r;
		logic signed [18:0] n;
		logic signed [16:0] sd;
		n = (19'(a) <<< 1) - 19'(lo) - 19'(hi);
		sd = 17'(hi) - 17'(lo);
		r.span = sd[15:0];
		r.neg = n[18];
		r.absn = n[18] ? 18'(-n) : 18'(n);
		r.sat = r.absn >= {1'b0, r.span, 1'b0};
		return r;
	endfunction

endpackage

>>> hw/rtl/compass_heading_calibrated.sv
// compass_heading_calibrated: min/max calibration, averaging, normalization
// by a shared restoring divider and CORDIC atan2 heading. Uses chc_pkg.
// Heading runs pass the averaging, the one-bit-per-cycle divider and the single
// CORDIC stage; a span error skips divider and CORDIC. Samples that do not end
// a run are taken in idle. One item in work at a time; the next transfer is
// taken the cycle after the result is loaded into the output register.
// Reset: calibration to full 16-bit range, counters and sums cleared.
module compass_heading_calibrated import chc_pkg::*; #(
	parameter int CAL_SAMPLES  = CAL_SAMPLES_DEF,
	parameter int AVG_SAMPLES  = AVG_SAMPLES_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [14:0]        heading,
	output logic               span_error
);

	// ceil(2^23 / AVG_SAMPLES), exact truncation for sums below 2^19
	localparam logic [23:0] AVG_RECIP = 24'(((1 << 23) + AVG_SAMPLES - 1) / AVG_SAMPLES);

	state_t state_q, state_d;

	logic signed [15:0] cal_min_x_q, cal_max_x_q, cal_min_y_q, cal_max_y_q;
	logic signed [15:0] run_min_x_q, run_max_x_q, run_min_y_q, run_max_y_q;
	logic [6:0] cal_count_q;
	logic [3:0] avg_count_q;
	logic signed [19:0] sum_x_q, sum_y_q;
	logic signed [15:0] ax_q;
	logic signed [17:0] qx_q;
	logic [15:0] rem_q, div_q;
	logic [19:0] dq_q;
	logic [4:0] it_q;
	logic neg_q, sat_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic kind_q;
	logic [14:0] head_q;
	logic out_valid_q, result_kind_q, span_error_q;
	logic [14:0] heading_q;

	logic acc, span_bad, fin_ld, it_last;
	logic signed [15:0] rmin_x, rmax_x, rmin_y, rmax_y;
	logic [6:0] cal_cnt_nxt;
	logic [3:0] avg_cnt_nxt;
	logic signed [19:0] sx_nxt, sy_nxt;
	logic [16:0] r2, r2_sub;
	logic r2_ge;
	logic [16:0] nmag;
	logic [19:0] avg_mag;
	logic avg_neg;
	logic [43:0] avg_prod;
	logic signed [15:0] avg_val;
	logic signed [17:0] q_val;
	norm_ld_t nl;
	logic signed [XW-1:0] xs, ys;
	logic signed [ZW-1:0] ang, zw;
	logic [16:0] hfull;

	function automatic logic signed [XW-1:0] q_val_x_abs(input logic signed [17:0] q);
		return q[17] ? -XW'(q) : XW'(q);
	endfunction

	assign acc = in_valid && in_ready;
	assign span_bad = (cal_max_x_q == cal_min_x_q) || (cal_max_y_q == cal_min_y_q);
	assign fin_ld = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign it_last = (it_q == '0);

	always_comb begin
		if (cal_count_q == '0) begin
			rmin_x = mag_x; rmax_x = mag_x;
			rmin_y = mag_y; rmax_y = mag_y;
		end else begin
			rmin_x = (mag_x < run_min_x_q) ? mag_x : run_min_x_q;
			rmax_x = (mag_x > run_max_x_q) ? mag_x : run_max_x_q;
			rmin_y = (mag_y < run_min_y_q) ? mag_y : run_min_y_q;
			rmax_y = (mag_y > run_max_y_q) ? mag_y : run_max_y_q;
		end
	end

	assign cal_cnt_nxt = cal_count_q + 7'd1;
	assign avg_cnt_nxt = avg_count_q + 4'd1;
	assign sx_nxt = sum_x_q + 20'(mag_x);
	assign sy_nxt = sum_y_q + 20'(mag_y);

	// run average by reciprocal multiply, truncated toward zero
	always_comb begin
		if (state_q == ST_AVGX) begin
			avg_neg = sum_x_q[19];
			avg_mag = sum_x_q[19] ? 20'(-sum_x_q) : 20'(sum_x_q);
		end else begin
			avg_neg = sum_y_q[19];
			avg_mag = sum_y_q[19] ? 20'(-sum_y_q) : 20'(sum_y_q);
		end
	end
	assign avg_prod = 44'(avg_mag) * 44'(AVG_RECIP);
	assign avg_val = avg_neg ? -16'(avg_prod[43:23]) : 16'(avg_prod[43:23]);

	// shared divider step
	assign r2 = {rem_q, dq_q[19]};
	assign r2_ge = r2 >= {1'b0, div_q};
	assign r2_sub = r2 - {1'b0, div_q};

	// quotient of the finishing division (final bit folded in)
	always_comb begin
		logic [19:0] qf;
		qf = {dq_q[18:0], r2_ge};
		nmag = (sat_q || qf[16:0] > Q_ONE) ? Q_ONE : qf[16:0];
		q_val = neg_q ? -18'(nmag) : 18'(nmag);
	end

	always_comb begin
		if (state_q == ST_AVGY)
			nl = norm_load(ax_q, cal_min_x_q, cal_max_x_q);
		else
			nl = norm_load(ax_q, cal_min_y_q, cal_max_y_q);
	end

	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign ang = atan_lut(it_q);

	always_comb begin
		logic signed [ZW-1:0] zn, zp;
		zn = (y_q > 0) ? z_q + ang : z_q - ang;
		zp = (zn < 0) ? zn + ANG_360 : zn;
		zw = (zp >= ANG_360) ? zp - ANG_360 : zp;
	end
	assign hfull = 17'((zw + ZW'(512)) >>> 10);

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (acc) begin
					if (!req_type && 32'(cal_cnt_nxt) >= CAL_SAMPLES)
						state_d = ST_FIN;
					else if (req_type && 32'(avg_cnt_nxt) >= AVG_SAMPLES)
						state_d = ST_AVGX;
				end
			end
			ST_AVGX:  state_d = ST_AVGY;
			ST_AVGY:  state_d = span_bad ? ST_FIN : ST_NORMX;
			ST_NORMX: if (it_last) state_d = ST_NORMY;
			ST_NORMY: if (it_last) state_d = (qx_q == '0 && q_val == '0) ? ST_FIN : ST_CORD;
			ST_CORD:  if (32'(it_q) == CORDIC_STEPS - 1) state_d = ST_FIN;
			ST_FIN:   if (fin_ld) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_min_x_q <= 16'sh8000;
			cal_max_x_q <= 16'sh7fff;
			cal_min_y_q <= 16'sh8000;
			cal_max_y_q <= 16'sh7fff;
			cal_count_q <= '0;
			avg_count_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc && !req_type) begin
				if (32'(cal_cnt_nxt) >= CAL_SAMPLES) begin
					cal_count_q <= '0;
					cal_min_x_q <= rmin_x;
					cal_max_x_q <= rmax_x;
					cal_min_y_q <= rmin_y;
					cal_max_y_q <= rmax_y;
				end else begin
					cal_count_q <= cal_cnt_nxt;
				end
			end
			if (acc && req_type) begin
				sum_x_q <= sx_nxt;
				sum_y_q <= sy_nxt;
				avg_count_q <= (32'(avg_cnt_nxt) >= AVG_SAMPLES) ? '0 : avg_cnt_nxt;
			end
			if (state_q == ST_AVGY) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
			end
			if (fin_ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !req_type) begin
			run_min_x_q <= rmin_x;
			run_max_x_q <= rmax_x;
			run_min_y_q <= rmin_y;
			run_max_y_q <= rmax_y;
			kind_q <= 1'b1;
			head_q <= '0;
		end
		if (acc && req_type) begin
			kind_q <= 1'b0;
			head_q <= '0;
		end
		unique case (state_q)
			ST_AVGX: ax_q <= avg_val;
			ST_AVGY, ST_NORMX, ST_NORMY: begin
				if (state_q != ST_AVGY && !it_last) begin
					rem_q <= r2_ge ? r2_sub[15:0] : r2[15:0];
					dq_q <= {dq_q[18:0], r2_ge};
					it_q <= it_q - 5'd1;
				end else if (state_q == ST_NORMY) begin
					x_q <= q_val_x_abs(qx_q);
					y_q <= qx_q[17] ? -XW'(q_val) : XW'(q_val);
					z_q <= qx_q[17] ? ANG_180 : '0;
					it_q <= '0;
				end else begin
					if (state_q == ST_AVGY) ax_q <= avg_val;
					else qx_q <= q_val;
					rem_q <= nl.absn[16:1];
					div_q <= nl.span;
					dq_q <= {nl.absn[0], 19'b0};
					neg_q <= nl.neg;
					sat_q <= nl.sat;
					it_q <= 5'd16;
				end
			end
			ST_CORD: begin
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
				end
				z_q <= (y_q > 0) ? z_q + ang : z_q - ang;
				it_q <= it_q + 5'd1;
				if (32'(it_q) == CORDIC_STEPS - 1)
					head_q <= (hfull >= H_WRAP) ? '0 : hfull[14:0];
			end
			default: ;
		endcase
		if (fin_ld) begin
			result_kind_q <= kind_q;
			heading_q <= span_bad ? '0 : head_q;
			span_error_q <= span_bad;
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = result_kind_q;
	assign heading = heading_q;
	assign span_error = span_error_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading < 15'd23040) else $error("heading out of range");
	a_cal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_kind || span_error)) |-> heading == '0)
		else $error("nonzero heading on calibration or error result");

endmodule

>>> test/tb.sv
// tb: self-checking testbench for compass_heading_calibrated.
// Predicts calibration commits and averaged CORDIC headings in a local model and
// checks every result transfer. Depends on chc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
	import chc_pkg::*;

	localparam int NCAL = CAL_SAMPLES_DEF;
	localparam int NAVG = AVG_SAMPLES_DEF;
	localparam int NSTEP = CORDIC_STEPS_DEF;
	localparam int N_RANDOM = 1400;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 200;

	localparam logic KIND_HEAD = 1'b0;
	localparam logic KIND_CAL = 1'b1;
	localparam logic REQ_CAL = 1'b0;
	localparam logic REQ_HEAD = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [14:0] hdg;
		logic        err;
	} compass_res_t;

	typedef struct {
		logic        rt;
		logic [15:0] x;
		logic [15:0] y;
		logic        has_exp;
		logic        exp_err;
	} vec_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               req_type = 1'b0;
	logic signed [15:0] mag_x = '0;
	logic signed [15:0] mag_y = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               result_kind;
	logic [14:0]        heading;
	logic               span_error;

	compass_heading_calibrated dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .mag_x(mag_x), .mag_y(mag_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .heading(heading), .span_error(span_error)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	int cmin_x, cmax_x, cmin_y, cmax_y;
	int rmin_x, rmax_x, rmin_y, rmax_y;
	int ncal_seen, navg_seen, acc_x, acc_y;
	compass_res_t pending_q[$];
	logic fixed_q[$];
	compass_res_t fixed_val_q[$];

	int n_err = 0;
	int n_res = 0;
	int n_cal_res = 0;
	int n_head_res = 0;
	int n_sent = 0;
	int idle_cnt = 0;
	int send_pct = 0;
	int stall_pct = 0;
	bit hold_off = 1'b0;
	bit run_done = 1'b0;

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint scale_axis(int v, int lo, int hi);
		longint s, n, q;
		s = longint'(hi) - lo;
		n = 2 * (longint'(v) - lo) - s;
		q = (n * 65536) / s;
		if (q > 65536) q = 65536;
		if (q < -65536) q = -65536;
		return q;
	endfunction

	function automatic logic [14:0] atan2_heading(longint x, longint y);
		longint z, xs, ys, a180, a360;
		longint h;
		a180 = longint'(180) * 65536;
		a360 = longint'(360) * 65536;
		z = 0;
		if (x == 0 && y == 0) return '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = a180;
		end
		for (int i = 0; i < NSTEP && i < 24; i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (y > 0) begin
				x += ys;
				y -= xs;
				z += longint'(atan_lut(5'(i)));
			end else begin
				x -= ys;
				y += xs;
				z -= longint'(atan_lut(5'(i)));
			end
		end
		if (z < 0) z += a360;
		if (z >= a360) z -= a360;
		h = (z + 512) >>> 10;
		if (h >= 23040) h = 0;
		return 15'(h);
	endfunction

	task automatic compass_reset_model();
		cmin_x = -32768; cmax_x = 32767;
		cmin_y = -32768; cmax_y = 32767;
		rmin_x = 0; rmax_x = 0; rmin_y = 0; rmax_y = 0;
		ncal_seen = 0; navg_seen = 0; acc_x = 0; acc_y = 0;
	endtask

	// returns 1 and fills r if the sample completes a run
	function automatic bit compass_step(logic rt, logic signed [15:0] sx,
			logic signed [15:0] sy, output compass_res_t r);
		int mx, my, ax, ay;
		mx = sx;
		my = sy;
		r = '0;
		if (rt == REQ_CAL) begin
			if (ncal_seen == 0) begin
				rmin_x = mx; rmax_x = mx; rmin_y = my; rmax_y = my;
			end else begin
				if (mx < rmin_x) rmin_x = mx;
				if (mx > rmax_x) rmax_x = mx;
				if (my < rmin_y) rmin_y = my;
				if (my > rmax_y) rmax_y = my;
			end
			ncal_seen++;
			if (ncal_seen < NCAL) return 1'b0;
			ncal_seen = 0;
			cmin_x = rmin_x; cmax_x = rmax_x; cmin_y = rmin_y; cmax_y = rmax_y;
			r.kind = KIND_CAL;
			r.err = (cmax_x == cmin_x) || (cmax_y == cmin_y);
			return 1'b1;
		end
		acc_x += mx;
		acc_y += my;
		navg_seen++;
		if (navg_seen < NAVG) return 1'b0;
		ax = acc_x / NAVG;
		ay = acc_y / NAVG;
		navg_seen = 0; acc_x = 0; acc_y = 0;
		r.kind = KIND_HEAD;
		if (cmax_x == cmin_x || cmax_y == cmin_y) begin
			r.err = 1'b1;
		end else begin
			r.hdg = atan2_heading(scale_axis(ax, cmin_x, cmax_x),
				scale_axis(ay, cmin_y, cmax_y));
		end
		return 1'b1;
	endfunction

	task automatic send_sample(logic rt, logic [15:0] x, logic [15:0] y,
			bit chk, logic chk_err);
		compass_res_t r;
		while (send_pct > 0 && $urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		req_type <= rt;
		mag_x <= x;
		mag_y <= y;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_sent++;
		if (compass_step(rt, x, y, r)) begin
			pending_q.push_back(r);
			fixed_q.push_back(chk);
			r.err = chk_err;
			fixed_val_q.push_back(r);
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_q.size() != 0) @(negedge clk);
	endtask

	task automatic send_cal_run(int lo_x, int hi_x, int lo_y, int hi_y, bit flat_x);
		for (int i = 0; i < NCAL; i++) begin
			logic [15:0] x, y;
			x = flat_x ? 16'(lo_x) : 16'($urandom_range(hi_x - lo_x) + lo_x);
			y = 16'($urandom_range(hi_y - lo_y) + lo_y);
			if (i == 0 && !flat_x) x = 16'(lo_x);
			if (i == 1 && !flat_x) x = 16'(hi_x);
			if (i == 2) y = 16'(lo_y);
			if (i == 3) y = 16'(hi_y);
			send_sample(REQ_CAL, x, y, 1'b0, 1'b0);
		end
	endtask

	task automatic send_head_run(bit wide);
		logic [15:0] bx, by;
		bx = 16'($urandom);
		by = 16'($urandom);
		for (int i = 0; i < NAVG; i++) begin
			if (wide)
				send_sample(REQ_HEAD, 16'($urandom), 16'($urandom), 1'b0, 1'b0);
			else
				send_sample(REQ_HEAD, bx + 16'($urandom_range(64)),
					by + 16'($urandom_range(64)), 1'b0, 1'b0);
		end
	endtask

	// result side
	always @(negedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		compass_res_t got, want, typed;
		bit use_typed;
		if (arst_n && in_valid && in_ready || arst_n && out_valid && out_ready)
			idle_cnt <= 0;
		else if (arst_n)
			idle_cnt <= idle_cnt + 1;
		if (arst_n && out_valid && out_ready) begin
			got = {result_kind, heading, span_error};
			n_res++;
			if (pending_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected result transfer %p", got);
			end else begin
				want = pending_q.pop_front();
				use_typed = fixed_q.pop_front();
				typed = fixed_val_q.pop_front();
				if (use_typed && typed.err != want.err) begin
					n_err++;
					if (n_err <= 10)
						$display("typed error flag %b disagrees with predictor", typed.err);
				end
				if (got.kind == KIND_CAL) n_cal_res++;
				else n_head_res++;
				if (got.kind != want.kind || got.hdg != want.hdg || got.err != want.err) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: exp kind=%b hdg=%0d err=%b, got kind=%b hdg=%0d err=%b",
							want.kind, want.hdg, want.err, got.kind, got.hdg, got.err);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!run_done && idle_cnt >= STALL_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cnt);
			$display("*** FAILED ***");
			$finish;
		end
	end

	vec_row_t vecs[$];

	initial begin
		compass_reset_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: headings against reset calibration, extremes, then a flat-span run
		for (int i = 0; i < NAVG; i++)
			vecs.push_back('{REQ_HEAD, 16'h8000, 16'h7fff, i == NAVG - 1, 1'b0});
		for (int i = 0; i < NAVG; i++)
			vecs.push_back('{REQ_HEAD, 16'h0000, 16'hffff, 1'b0, 1'b0});
		foreach (vecs[i]) send_sample(vecs[i].rt, vecs[i].x, vecs[i].y,
			vecs[i].has_exp, vecs[i].exp_err);
		// flat X span: commit flags error, heading then errors too
		send_cal_run(100, 100, -500, 500, 1'b1);
		send_head_run(1'b0);
		wait_drained();
		// full-range calibration, then a narrower one whose out of range average saturates
		send_cal_run(-32768, 32767, -32768, 32767, 1'b0);
		for (int i = 0; i < NAVG; i++)
			send_sample(REQ_HEAD, 16'h7fff, 16'h7fff, 1'b0, 1'b0);
		send_cal_run(-1000, 1000, -2000, 2000, 1'b0);
		for (int i = 0; i < NAVG; i++)
			send_sample(REQ_HEAD, 16'h7fff, 16'h8000, 1'b0, 1'b0);

		// long receiver hold-off while samples keep coming
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			begin
				repeat (4) send_head_run(1'b0);
				in_valid <= 1'b0;
				@(negedge clk);
			end
		join
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_pct = 0; stall_pct = 0; end
				1: begin send_pct = 48; stall_pct = 0; end
				2: begin send_pct = 0; stall_pct = 48; end
				default: begin send_pct = 9; stall_pct = 9; end
			endcase
			while (n_sent < 150 + (ph + 1) * N_RANDOM / 4) begin
				int pick;
				pick = $urandom_range(99);
				if (pick < 8) begin
					int lx, ly;
					lx = $urandom_range(60000) - 32768;
					ly = $urandom_range(60000) - 32768;
					send_cal_run(lx, lx + 1 + $urandom_range(32767 - lx - 1 < 4000 ?
						32767 - lx - 1 : 4000), ly, ly + 1 + $urandom_range(
						32767 - ly - 1 < 4000 ? 32767 - ly - 1 : 4000), 1'b0);
				end else if (pick < 75) begin
					send_head_run(1'b0);
				end else if (pick < 85) begin
					send_head_run(1'b1);
				end else begin
					send_sample($urandom_range(1), 16'($urandom), 16'($urandom),
						1'b0, 1'b0);
				end
			end
			wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		run_done = 1'b1;
		$display("sent %0d samples; checked %0d calibration and %0d heading results",
			n_sent, n_cal_res, n_head_res);
		if (n_err == 0 && pending_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", n_err, pending_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/chc_pkg.sv
hw/rtl/compass_heading_calibrated.sv
test/tb.sv
